@@ hw/rtl/cmfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cmfb_pkg
// Shared types, register indexes, mask kinds and the divide-by-255 helper
// for the colour mask fill blend unit.
// ----------------------------------------------------------------------------
package cmfb_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KIND_W    = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_OPACITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_KIND    = 3'd4;

  // Mask kinds.
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FULL = 8'hff;

  // Reset values of the registers.
  localparam logic [7:0]        RST_FILL_OPACITY = BYTE_FULL;
  localparam logic [KIND_W-1:0] RST_MASK_KIND    = KIND_ALPHA;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic replace;
    logic blend;
  } mode_t;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

@@ hw/rtl/cmfb_alpha.sv @@
// ----------------------------------------------------------------------------
// cmfb_alpha
// First two pipeline stages: decide between keep, replace and blend, and
// derive the effective alpha, scaling the mask by the opacity when needed.
// ----------------------------------------------------------------------------
module cmfb_alpha
  import cmfb_pkg::*;
(
  input  logic              clk,
  input  logic              ld1,
  input  logic              ld2,
  input  logic [7:0]        mask_alpha,
  input  pix_t              dst_in,
  input  logic [7:0]        fill_opacity,
  input  logic [KIND_W-1:0] mask_kind,
  output logic [7:0]        alpha,
  output mode_t             mode,
  output pix_t              dst_out
);

  logic [7:0]  a_dir_nxt, a_dir_r;
  logic        scale_nxt, scale_r;
  mode_t       mode_nxt, mode1_r, mode2_r;
  logic [15:0] prod_r;
  pix_t        dst1_r, dst2_r;
  logic [7:0]  alpha2_r;
  logic        op_full, m_set;

  assign op_full = (fill_opacity == BYTE_FULL);
  assign m_set   = (mask_alpha != BYTE_ZERO);

  always_comb begin
    mode_nxt  = '0;
    a_dir_nxt = fill_opacity;
    scale_nxt = 1'b0;
    if (fill_opacity != BYTE_ZERO) begin
      unique case (mask_kind)
        KIND_NONE: begin
          mode_nxt.replace = op_full;
          mode_nxt.blend   = !op_full;
        end
        KIND_BIT: begin
          mode_nxt.replace = m_set && op_full;
          mode_nxt.blend   = m_set && !op_full;
        end
        KIND_ALPHA: begin
          if (m_set) begin
            if (op_full) begin
              mode_nxt.replace = (mask_alpha == BYTE_FULL);
              mode_nxt.blend   = (mask_alpha != BYTE_FULL);
              a_dir_nxt        = mask_alpha;
            end else begin
              mode_nxt.blend = 1'b1;
              scale_nxt      = 1'b1;
            end
          end
        end
        default: mode_nxt = '0;
      endcase
    end
  end

  // Stage 1: decision and mask times opacity.
  always_ff @(posedge clk) begin
    if (ld1) begin
      mode1_r <= mode_nxt;
      a_dir_r <= a_dir_nxt;
      scale_r <= scale_nxt;
      prod_r  <= 16'(mask_alpha) * 16'(fill_opacity);
      dst1_r  <= dst_in;
    end
  end

  // Stage 2: effective alpha.
  always_ff @(posedge clk) begin
    if (ld2) begin
      alpha2_r <= scale_r ? div255(prod_r) : a_dir_r;
      mode2_r  <= mode1_r;
      dst2_r   <= dst1_r;
    end
  end

  assign alpha   = alpha2_r;
  assign mode    = mode2_r;
  assign dst_out = dst2_r;

endmodule

@@ hw/rtl/cmfb_chan.sv @@
// ----------------------------------------------------------------------------
// cmfb_chan
// Stages three and four for one colour channel: the two blend products,
// then their floored quotients, the saturating sum and the result select.
// ----------------------------------------------------------------------------
module cmfb_chan
  import cmfb_pkg::*;
(
  input  logic       clk,
  input  logic       ld3,
  input  logic       ld4,
  input  logic [7:0] dst,
  input  logic [7:0] col,
  input  logic [7:0] alpha,
  input  mode_t      mode,
  output logic [7:0] res
);

  logic [15:0] pd_r, pc_r;
  logic [7:0]  dst3_r, res_r;
  mode_t       mode3_r;
  logic [8:0]  sum;
  logic [7:0]  mixed;

  // Stage 3: dst * (255 - a) and col * a.
  always_ff @(posedge clk) begin
    if (ld3) begin
      pd_r    <= 16'(dst) * 16'(BYTE_FULL - alpha);
      pc_r    <= 16'(col) * 16'(alpha);
      dst3_r  <= dst;
      mode3_r <= mode;
    end
  end

  assign sum   = {1'b0, div255(pd_r)} + {1'b0, div255(pc_r)};
  assign mixed = sum[8] ? BYTE_FULL : sum[7:0];

  // Stage 4: result register, which is also the output register.
  always_ff @(posedge clk) begin
    if (ld4) begin
      if (mode3_r.replace) begin
        res_r <= col;
      end else if (mode3_r.blend) begin
        res_r <= mixed;
      end else begin
        res_r <= dst3_r;
      end
    end
  end

  assign res = res_r;

endmodule

@@ hw/rtl/color_mask_fill_blend_unit.sv @@
// ----------------------------------------------------------------------------
// color_mask_fill_blend_unit
// Fills a stream of destination pixels with a configured colour under a
// mask, with global opacity, and flags which pixels were written.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  in_*      slave      tdata: mask_alpha, dest_red, dest_green, dest_blue
//  out_*     master     tdata: out_red, out_green, out_blue; tuser: written
//  cfg_*     slave      cfg_index (register), cfg_data (value)
//
// One beat is taken per clock cycle unless the full pipeline is stalled,
// and each input beat yields exactly one output beat: stage one decides
// the operation and forms mask times opacity, stage two divides that by
// 255, stage three forms the two blend products per channel and stage four
// divides, sums, saturates and holds the result in the output register.
// Each stage carries its own valid bit and moves on whenever the next
// stage is empty or moving, so a stall on the output loses and repeats
// nothing and bubbles are squeezed out. rst_n is synchronous, active low;
// it empties the pipeline and sets the registers to their reset values.
// Configuration writes are always taken (cfg_ready is tied high); indexes
// beyond the register list are ignored.
// ----------------------------------------------------------------------------
module color_mask_fill_blend_unit
  import cmfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // mask_alpha, dest_red, dest_green, dest_blue
  // Output stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // out_red, out_green, out_blue
  output logic                 out_tuser,  // written
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // Configuration registers.
  logic [7:0]        fill_red_r, fill_green_r, fill_blue_r, fill_opacity_r;
  logic [KIND_W-1:0] mask_kind_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_red_r     <= BYTE_ZERO;
      fill_green_r   <= BYTE_ZERO;
      fill_blue_r    <= BYTE_ZERO;
      fill_opacity_r <= RST_FILL_OPACITY;
      mask_kind_r    <= RST_MASK_KIND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FILL_RED:     fill_red_r     <= cfg_data;
        CFG_FILL_GREEN:   fill_green_r   <= cfg_data;
        CFG_FILL_BLUE:    fill_blue_r    <= cfg_data;
        CFG_FILL_OPACITY: fill_opacity_r <= cfg_data;
        CFG_MASK_KIND:    mask_kind_r    <= cfg_data[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage advances when it is empty or when the
  // stage after it advances.
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_tready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // Stages one and two.
  pix_t       dst_in, dst2;
  logic [7:0] alpha2;
  mode_t      mode2;

  assign dst_in.red   = in_tdata[15:8];
  assign dst_in.green = in_tdata[23:16];
  assign dst_in.blue  = in_tdata[31:24];

  cmfb_alpha u_alpha (
    .clk          (clk),
    .ld1          (adv1),
    .ld2          (adv2),
    .mask_alpha   (in_tdata[7:0]),
    .dst_in       (dst_in),
    .fill_opacity (fill_opacity_r),
    .mask_kind    (mask_kind_r),
    .alpha        (alpha2),
    .mode         (mode2),
    .dst_out      (dst2)
  );

  // Stages three and four, one lane per channel.
  pix_t res;

  cmfb_chan u_chan_red (
    .clk   (clk),
    .ld3   (adv3),
    .ld4   (adv4),
    .dst   (dst2.red),
    .col   (fill_red_r),
    .alpha (alpha2),
    .mode  (mode2),
    .res   (res.red)
  );

  cmfb_chan u_chan_green (
    .clk   (clk),
    .ld3   (adv3),
    .ld4   (adv4),
    .dst   (dst2.green),
    .col   (fill_green_r),
    .alpha (alpha2),
    .mode  (mode2),
    .res   (res.green)
  );

  cmfb_chan u_chan_blue (
    .clk   (clk),
    .ld3   (adv3),
    .ld4   (adv4),
    .dst   (dst2.blue),
    .col   (fill_blue_r),
    .alpha (alpha2),
    .mode  (mode2),
    .res   (res.blue)
  );

  // The written flag follows the pixel through stages three and four.
  logic wr3_r, wr4_r;

  always_ff @(posedge clk) begin
    if (adv3) wr3_r <= mode2.replace || mode2.blend;
    if (adv4) wr4_r <= wr3_r;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = res;
  assign out_tuser  = wr4_r;

  // An empty pipeline must be able to take a beat.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !v2_r && !v3_r && !v4_r) |-> in_tready)
    else $error("pipeline empty but input not ready");

  // A decision is never both replace and blend.
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !(mode2.replace && mode2.blend))
    else $error("replace and blend both set");

  // A held item in the middle of the pipeline is not dropped.
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv2) |=> v2_r)
    else $error("stalled stage two item lost");

  // An item leaving stage three always finds room in stage four.
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && adv3) |=> v4_r)
    else $error("stage three item did not reach the output register");

endmodule
